FILE: hw/rtl/urs_pkg.sv
// Shared types and constants for the ultrasonic range sweep controller.
`default_nettype none

package urs_pkg;

    // Event codes carried in the opcode field
    localparam logic [2:0] OP_MODE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_MS    = 3'd2;
    localparam logic [2:0] OP_US    = 3'd3;
    localparam logic [2:0] OP_ECHO  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_TRIG_W    = 3'd0;
    localparam logic [2:0] REG_LED_HOLD  = 3'd1;
    localparam logic [2:0] REG_SWEEP_PER = 3'd2;
    localparam logic [2:0] REG_SERVO_MIN = 3'd3;
    localparam logic [2:0] REG_SERVO_STP = 3'd4;
    localparam logic [2:0] REG_SERVO_SPN = 3'd5;
    localparam logic [2:0] REG_DEADBAND  = 3'd6;
    localparam logic [2:0] REG_DIVISOR   = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_TRIG_W    = 8'd15;
    localparam logic [15:0] RST_LED_HOLD  = 16'd500;
    localparam logic [15:0] RST_SWEEP_PER = 16'd2000;
    localparam logic [15:0] RST_SERVO_MIN = 16'd1000;
    localparam logic [15:0] RST_SERVO_STP = 16'd250;
    localparam logic [15:0] RST_SERVO_SPN = 16'd1000;
    localparam logic [15:0] RST_DEADBAND  = 16'd20;
    localparam logic [15:0] RST_DIVISOR   = 16'd58;
    localparam logic [15:0] RST_SERVO     = 16'd1000;

    localparam logic [15:0] MAX16 = 16'hFFFF;

    // Range bar thresholds in centimeters
    localparam logic [15:0] BAR_OFF_ABOVE  = 16'd80;
    localparam logic [15:0] BAR_PAIR_BELOW = 16'd60;
    localparam logic [15:0] BAR_ALL_BELOW  = 16'd10;
    localparam logic [4:0]  BAR_ALL        = 5'b11111;
    localparam logic [4:0]  BAR_PAIR       = 5'b00011;

    // Full-scale potentiometer reading, the pot scaling divisor
    localparam logic [27:0] POT_FULL = 28'd4095;

    localparam int DIV_BITS  = 16;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    typedef struct packed {
        logic [7:0]  trigger_width_us;
        logic [15:0] led_hold_ms;
        logic [15:0] sweep_period_ms;
        logic [15:0] servo_min_us;
        logic [15:0] servo_step_us;
        logic [15:0] servo_span_us;
        logic [15:0] servo_deadband_us;
        logic [15:0] echo_divisor;
    } t_cfg;

    typedef struct packed {
        logic exec;
        logic div_step;
        logic mul;
        logic recip;
        logic corr_step;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic second_edge;
        logic auto_mode;
        logic div_last;
        logic corr_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/ultrasonic_range_sweep_controller_core.sv
// Top level of the ultrasonic range sweep controller: register port, sequencer, datapath.
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ------------------------------------
//  event     in         i_in_valid / o_in_stall     i_opcode, i_pot_sample
//  result    out        o_out_valid / i_out_stall   o_auto_mode .. o_sweep_last
//  config    in         psel / penable / pready     paddr, pwdata, pwrite, prdata
//
// Each event beat steps through accept, execute and result load. A second echo
// edge adds the bit-serial echo divider, then a commit step; in manual mode the
// pot reading is scaled between those two (multiply, reciprocal estimate,
// correction). A stalled result beat holds the block in its load step.
// Reset is synchronous and clears all event state and loads register defaults.
`default_nettype none

module ultrasonic_range_sweep_controller_core #(
    parameter int SWEEP_POSITIONS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [11:0] i_pot_sample,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_auto_mode,
    output logic             o_trigger_out,
    output logic             o_measure_led,
    output logic [4:0]       o_range_leds,
    output logic [15:0]      o_servo_pulse_us,
    output logic [15:0]      o_distance_cm,
    output logic             o_distance_valid,
    output logic [2:0]       o_sweep_index,
    output logic             o_sweep_last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import urs_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  busy;
    logic  in_accept;
    logic  out_accept;
    logic  out_free;
    logic  cfg_write;
    logic  r_out_valid;
    logic  [2:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file; the user must write only while the block is quiet, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_width_us  <= RST_TRIG_W;
            r_cfg.led_hold_ms       <= RST_LED_HOLD;
            r_cfg.sweep_period_ms   <= RST_SWEEP_PER;
            r_cfg.servo_min_us      <= RST_SERVO_MIN;
            r_cfg.servo_step_us     <= RST_SERVO_STP;
            r_cfg.servo_span_us     <= RST_SERVO_SPN;
            r_cfg.servo_deadband_us <= RST_DEADBAND;
            r_cfg.echo_divisor      <= RST_DIVISOR;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_TRIG_W:    r_cfg.trigger_width_us  <= pwdata[7:0];
                REG_LED_HOLD:  r_cfg.led_hold_ms       <= pwdata[15:0];
                REG_SWEEP_PER: r_cfg.sweep_period_ms   <= pwdata[15:0];
                REG_SERVO_MIN: r_cfg.servo_min_us      <= pwdata[15:0];
                REG_SERVO_STP: r_cfg.servo_step_us     <= pwdata[15:0];
                REG_SERVO_SPN: r_cfg.servo_span_us     <= pwdata[15:0];
                REG_DEADBAND:  r_cfg.servo_deadband_us <= pwdata[15:0];
                REG_DIVISOR:   r_cfg.echo_divisor      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_TRIG_W:    prdata = {24'd0, r_cfg.trigger_width_us};
            REG_LED_HOLD:  prdata = {16'd0, r_cfg.led_hold_ms};
            REG_SWEEP_PER: prdata = {16'd0, r_cfg.sweep_period_ms};
            REG_SERVO_MIN: prdata = {16'd0, r_cfg.servo_min_us};
            REG_SERVO_STP: prdata = {16'd0, r_cfg.servo_step_us};
            REG_SERVO_SPN: prdata = {16'd0, r_cfg.servo_span_us};
            REG_DEADBAND:  prdata = {16'd0, r_cfg.servo_deadband_us};
            REG_DIVISOR:   prdata = {16'd0, r_cfg.echo_divisor};
            default:       prdata = '0;
        endcase
    end

    // Take a new event only when the sequencer is idle
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    // The result register is free when empty or draining this cycle
    assign out_accept  = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    urs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    urs_dp #(
        .SWEEP_POSITIONS (SWEEP_POSITIONS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (in_accept),
        .i_opcode         (i_opcode),
        .i_pot_sample     (i_pot_sample),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_auto_mode      (o_auto_mode),
        .o_trigger_out    (o_trigger_out),
        .o_measure_led    (o_measure_led),
        .o_range_leds     (o_range_leds),
        .o_servo_pulse_us (o_servo_pulse_us),
        .o_distance_cm    (o_distance_cm),
        .o_distance_valid (o_distance_valid),
        .o_sweep_index    (o_sweep_index),
        .o_sweep_last     (o_sweep_last)
    );

    // An accepted event keeps the input side stalled until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accepting an event");

    // Manual-mode measurements carry no sweep position
    a_manual_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_distance_valid && !o_auto_mode) |->
            (o_sweep_index == 3'd0) && !o_sweep_last)
        else $error("sweep position reported in manual mode");

    // The last-position flag only accompanies the final sweep index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sweep_last) |->
            (o_sweep_index == 3'(SWEEP_POSITIONS - 1)) && o_distance_valid)
        else $error("sweep_last with wrong index");

    // A result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/urs_ctrl.sv
// Sequencer for the ranging controller: steps each event through the datapath.
`default_nettype none

module urs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_free,
    input  wire urs_pkg::t_stat i_stat,
    output urs_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import urs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_RECIP,
        S_CORR,
        S_COMMIT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC:   n_state = i_stat.second_edge ? S_DIV : S_FIN;
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = i_stat.auto_mode ? S_COMMIT : S_MUL;
                end
            end
            S_MUL:    n_state = S_RECIP;
            S_RECIP:  n_state = S_CORR;
            S_CORR:   if (i_stat.corr_done) n_state = S_COMMIT;
            S_COMMIT: n_state = S_FIN;
            S_FIN:    if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.recip     = (r_state == S_RECIP);
        o_cmd.corr_step = (r_state == S_CORR);
        o_cmd.commit    = (r_state == S_COMMIT);
        o_cmd.load_out  = (r_state == S_FIN) && i_out_free;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/urs_dp.sv
// Datapath: event state, echo divider, pot scaling and the result register.
`default_nettype none

module urs_dp #(
    parameter int SWEEP_POSITIONS = 5
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [11:0]    i_pot_sample,
    input  wire urs_pkg::t_cfg  i_cfg,
    input  wire urs_pkg::t_cmd  i_cmd,
    output urs_pkg::t_stat      o_stat,
    output logic                o_auto_mode,
    output logic                o_trigger_out,
    output logic                o_measure_led,
    output logic [4:0]          o_range_leds,
    output logic [15:0]         o_servo_pulse_us,
    output logic [15:0]         o_distance_cm,
    output logic                o_distance_valid,
    output logic [2:0]          o_sweep_index,
    output logic                o_sweep_last
);
    import urs_pkg::*;

    localparam logic [2:0] SWEEP_END  = 3'(SWEEP_POSITIONS);
    localparam logic [2:0] SWEEP_LAST = 3'(SWEEP_POSITIONS - 1);

    // Architectural state
    logic        r_mode,     n_mode;
    logic        r_phase,    n_phase;
    logic [15:0] r_fet,      n_fet;
    logic [15:0] r_mc,       n_mc;
    logic        r_run,      n_run;
    logic        r_trig,     n_trig;
    logic        r_led,      n_led;
    logic [15:0] r_led_cd,   n_led_cd;
    logic [15:0] r_step_cd,  n_step_cd;
    logic [2:0]  r_step_cnt, n_step_cnt;
    logic [15:0] r_servo,    n_servo;
    logic [4:0]  r_bar,      n_bar;
    logic [15:0] r_dist,     n_dist;
    logic        r_valid,    n_valid;
    logic [2:0]  r_sidx,     n_sidx;
    logic        r_slast,    n_slast;

    // Work registers
    logic [2:0]           r_op;
    logic [11:0]          r_pot;
    logic [15:0]          r_quo;
    logic [15:0]          r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [27:0]          r_prod;
    logic [16:0]          r_q;
    logic [27:0]          r_r;

    logic [16:0] step_sum;
    logic [15:0] step_sat;
    logic [17:0] tgt_sum;
    logic [15:0] target;
    logic [15:0] diff;
    logic [16:0] rem_sh;
    logic        q_bit;
    logic [15:0] rem_next;
    logic [16:0] q0;
    logic [28:0] q0_mul;
    logic [28:0] r_init;

    assign step_sum = {1'b0, r_servo} + {1'b0, i_cfg.servo_step_us};
    assign step_sat = step_sum[16] ? MAX16 : step_sum[15:0];
    assign tgt_sum  = {2'b00, i_cfg.servo_min_us} + {1'b0, r_q};
    assign target   = (tgt_sum[17:16] != 2'b00) ? MAX16 : tgt_sum[15:0];
    assign diff     = (target > r_servo) ? (target - r_servo) : (r_servo - target);

    // One restoring division step per cycle
    assign rem_sh   = {r_rem, r_quo[15]};
    assign q_bit    = (rem_sh >= {1'b0, i_cfg.echo_divisor});
    assign rem_next = q_bit ? 16'(rem_sh - {1'b0, i_cfg.echo_divisor}) : rem_sh[15:0];

    // Estimate of prod/4095 from prod/4096 + prod/4096^2, never above the true quotient
    assign q0     = {1'b0, r_prod[27:12]} + {13'd0, r_prod[27:24]};
    assign q0_mul = {q0, 12'd0} - {12'd0, q0};
    assign r_init = {1'b0, r_prod} - q0_mul;

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_fet      = r_fet;
        n_mc       = r_mc;
        n_run      = r_run;
        n_trig     = r_trig;
        n_led      = r_led;
        n_led_cd   = r_led_cd;
        n_step_cd  = r_step_cd;
        n_step_cnt = r_step_cnt;
        n_servo    = r_servo;
        n_bar      = r_bar;
        n_dist     = r_dist;
        n_valid    = r_valid;
        n_sidx     = r_sidx;
        n_slast    = r_slast;

        if (i_cmd.exec) begin
            n_valid = 1'b0;
            n_sidx  = '0;
            n_slast = 1'b0;
            case (r_op)
                OP_MODE: n_mode = ~r_mode;
                OP_START: begin
                    n_led    = 1'b1;
                    n_led_cd = i_cfg.led_hold_ms;
                    if (r_mode) begin
                        n_step_cnt = '0;
                        n_servo    = i_cfg.servo_min_us;
                        n_step_cd  = i_cfg.sweep_period_ms;
                    end
                    n_trig = 1'b1;
                    n_mc   = '0;
                    n_run  = 1'b1;
                end
                OP_MS: begin
                    // LED countdown first, then the sweep step countdown
                    if (r_led_cd != '0) begin
                        n_led_cd = r_led_cd - 16'd1;
                        if (n_led_cd == '0) n_led = 1'b0;
                    end
                    if (r_step_cd != '0) begin
                        n_step_cd = r_step_cd - 16'd1;
                        if ((n_step_cd == '0) && r_mode) begin
                            n_step_cnt = r_step_cnt + 3'd1;
                            if (n_step_cnt < SWEEP_END) begin
                                n_servo   = step_sat;
                                n_trig    = 1'b1;
                                n_mc      = '0;
                                n_run     = 1'b1;
                                n_led     = 1'b1;
                                n_led_cd  = i_cfg.led_hold_ms;
                                n_step_cd = i_cfg.sweep_period_ms;
                            end
                        end
                    end
                end
                OP_US: begin
                    if (r_run) begin
                        n_mc = r_mc + 16'd1;
                        if (n_mc == {8'd0, i_cfg.trigger_width_us}) n_trig = 1'b0;
                    end
                end
                OP_ECHO: begin
                    if (!r_phase) begin
                        n_fet   = r_mc;
                        n_phase = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.commit) begin
            n_phase = 1'b0;
            n_run   = 1'b0;
            n_dist  = r_quo;
            n_valid = 1'b1;
            if (r_mode) begin
                n_sidx  = r_step_cnt;
                n_slast = (r_step_cnt == SWEEP_LAST);
            end else if (diff > i_cfg.servo_deadband_us) begin
                n_servo = target;
            end
            if (r_quo > BAR_OFF_ABOVE) begin
                n_bar = '0;
            end else if (r_quo < BAR_ALL_BELOW) begin
                n_bar = BAR_ALL;
            end else if (r_quo < BAR_PAIR_BELOW) begin
                n_bar = r_bar | BAR_PAIR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_phase    <= 1'b0;
            r_fet      <= '0;
            r_mc       <= '0;
            r_run      <= 1'b0;
            r_trig     <= 1'b0;
            r_led      <= 1'b0;
            r_led_cd   <= '0;
            r_step_cd  <= '0;
            r_step_cnt <= '0;
            r_servo    <= RST_SERVO;
            r_bar      <= '0;
            r_dist     <= '0;
            r_valid    <= 1'b0;
            r_sidx     <= '0;
            r_slast    <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_fet      <= n_fet;
            r_mc       <= n_mc;
            r_run      <= n_run;
            r_trig     <= n_trig;
            r_led      <= n_led;
            r_led_cd   <= n_led_cd;
            r_step_cd  <= n_step_cd;
            r_step_cnt <= n_step_cnt;
            r_servo    <= n_servo;
            r_bar      <= n_bar;
            r_dist     <= n_dist;
            r_valid    <= n_valid;
            r_sidx     <= n_sidx;
            r_slast    <= n_slast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op  <= i_opcode;
            r_pot <= i_pot_sample;
        end
        if (i_cmd.exec) begin
            r_quo <= r_mc - r_fet;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[14:0], q_bit};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= 28'(r_pot) * 28'(i_cfg.servo_span_us);
        end
        if (i_cmd.recip) begin
            r_q <= q0;
            r_r <= r_init[27:0];
        end
        if (i_cmd.corr_step && (r_r >= POT_FULL)) begin
            r_r <= r_r - POT_FULL;
            r_q <= r_q + 17'd1;
        end
        if (i_cmd.load_out) begin
            o_auto_mode      <= r_mode;
            o_trigger_out    <= r_trig;
            o_measure_led    <= r_led;
            o_range_leds     <= r_bar;
            o_servo_pulse_us <= r_servo;
            o_distance_cm    <= r_dist;
            o_distance_valid <= r_valid;
            o_sweep_index    <= r_sidx;
            o_sweep_last     <= r_slast;
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.second_edge = (r_op == OP_ECHO) && r_phase;
        o_stat.auto_mode   = r_mode;
        o_stat.div_last    = (r_cnt == DIV_CNT_W'(DIV_BITS - 1));
        o_stat.corr_done   = (r_r < POT_FULL);
    end

endmodule

`default_nettype wire
